>>> sv/smt_pkg.sv
`default_nettype none
package smt_pkg;

  // Table depth
  localparam int MAX_ENTRIES = 8;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int COUNT_W = 4;
  localparam int ID_W = 16;
  localparam int TAG_W = 2;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_RENAME = 3'd3,
    CMD_LOOKUP = 3'd4
  } cmd_code_t;

  localparam logic [TAG_W-1:0] TAG_NONE = 2'd0;
  localparam logic [TAG_W-1:0] TAG_TOP  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_END  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [ID_W-1:0]  seg_id;
    logic [ID_W-1:0]  new_seg_id;
    logic [TAG_W-1:0] tag_in;
    logic             swap_ends;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [TAG_W-1:0]   tag_out;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic done;
    rsp_t rsp;
  } seq_out_t;

  // Top and end trade places when swap is set; every other tag stays
  function automatic logic [TAG_W-1:0] swap_tag(input logic [TAG_W-1:0] tag, input logic swap);
    logic [TAG_W-1:0] res;
    res = tag;
    if (swap && tag == TAG_TOP) begin
      res = TAG_END;
    end else if (swap && tag == TAG_END) begin
      res = TAG_TOP;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> sv/segment_membership_table.sv
`default_nettype none
// Ordered table of up to MAX_ENTRIES segment IDs with two-bit position tags, taking clear,
// add, remove, rename and lookup commands and answering each with one transaction carrying
// ok, tag_out and count. The entries live in a chain of cells that rotates once round per
// command: the sequencer sees one entry a cycle at the head, save where the last step holds,
// and feeds the same, a renamed, a newly added or (after a removal) the following entry
// back in at the tail, so the table is rewritten in order as it turns. A command is accepted
// in idle and then steps once through every entry of the rotation before the next command
// can be accepted. The last rotation step holds while an earlier result still sits
// unaccepted in the output register; a new command is taken while a result waits.
module segment_membership_table
  import smt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  entry_t   cell_q [MAX_ENTRIES];
  entry_t   emit;
  logic     shift;
  logic     out_busy;
  seq_out_t result;

  // Output slot is busy while a result waits to be taken
  assign out_busy = rsp_valid && rsp_stall;

  smt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .out_busy  (out_busy),
    .head      (cell_q[0]),
    .second    (cell_q[1]),
    .emit      (emit),
    .shift     (shift),
    .result    (result)
  );

  // Chain of cells: each takes its upper neighbour's entry; the top cell takes the tail feed
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i < MAX_ENTRIES - 1) begin : g_mid
      smt_cell u_cell (
        .clk   (clk),
        .shift (shift),
        .nxt   (cell_q[i+1]),
        .cur   (cell_q[i])
      );
    end else begin : g_tail
      smt_cell u_cell (
        .clk   (clk),
        .shift (shift),
        .nxt   (emit),
        .cur   (cell_q[i])
      );
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (result.done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.done) begin
      rsp <= result.rsp;
    end
  end

  // A result is never produced over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result.done |-> !out_busy)
    else $error("result produced while output slot busy");

  // A finished command always shows up at the output
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    result.done |=> rsp_valid)
    else $error("finished command not presented");

  // Once a command is taken, req_stall is raised as its rotation starts
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("command accepted during rotation");

endmodule
`default_nettype wire

>>> sv/smt_cell.sv
`default_nettype none
module smt_cell
  import smt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   shift,
  input  wire entry_t nxt,
  output entry_t      cur
);

  entry_t ent;

  always_ff @(posedge clk) begin
    if (shift) begin
      ent <= nxt;
    end
  end

  assign cur = ent;

endmodule
`default_nettype wire

>>> sv/smt_seq.sv
`default_nettype none
module smt_seq
  import smt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   req_valid,
  input  wire req_t   req,
  output logic        req_stall,
  input  wire logic   out_busy,
  input  wire entry_t head,
  input  wire entry_t second,
  output entry_t      emit,
  output logic        shift,
  output seq_out_t    result
);

  state_t           state, state_next;
  logic [IDX_W-1:0] step, step_next;
  logic [CNT_W-1:0] count, count_next;
  logic             found, found_next;
  logic [TAG_W-1:0] tag_res, tag_res_next;

  logic [2:0]       op;
  logic [ID_W-1:0]  key;
  logic [ID_W-1:0]  new_id;
  logic [TAG_W-1:0] tag_new;
  logic             swap;

  logic             last;
  logic             in_range;
  logic             hit;
  logic             accept;
  logic             add_ok;

  assign last     = (step == IDX_W'(MAX_ENTRIES - 1));
  assign in_range = (CNT_W'(step) < count);
  assign hit      = in_range && (head.id == key);
  assign accept   = (state == ST_IDLE) && req_valid;
  assign add_ok   = !(found || hit) && (count < CNT_W'(MAX_ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      step    <= '0;
      count   <= '0;
      found   <= 1'b0;
      tag_res <= TAG_NONE;
    end else begin
      state   <= state_next;
      step    <= step_next;
      count   <= count_next;
      found   <= found_next;
      tag_res <= tag_res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= req.cmd;
      key     <= req.seg_id;
      new_id  <= req.new_seg_id;
      tag_new <= req.tag_in;
      swap    <= req.swap_ends;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    count_next   = count;
    found_next   = found;
    tag_res_next = tag_res;
    emit         = head;
    shift        = 1'b0;
    result       = '0;
    req_stall    = (state != ST_IDLE);

    // what re-enters the tail of the chain this step
    unique case (op)
      CMD_ADD: begin
        if ((CNT_W'(step) == count) && !found) begin
          emit.id  = key;
          emit.tag = tag_new;
        end
      end
      CMD_REMOVE: begin
        if (found || hit) begin
          emit = second;
        end
      end
      CMD_RENAME: begin
        if (hit) begin
          emit.id  = new_id;
          emit.tag = swap_tag(head.tag, swap);
        end
      end
      default: begin
        emit = head;
      end
    endcase

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next   = ST_SCAN;
          step_next    = '0;
          found_next   = 1'b0;
          tag_res_next = TAG_NONE;
        end
      end
      ST_SCAN: begin
        shift = !(last && out_busy);
        if (shift) begin
          found_next = found || hit;
          if ((op == CMD_LOOKUP) && hit && !found) begin
            tag_res_next = head.tag;
          end
          step_next = IDX_W'(step + 1'b1);
          if (last) begin
            state_next  = ST_IDLE;
            result.done = 1'b1;
            unique case (op)
              CMD_CLEAR: begin
                result.rsp.ok = 1'b1;
                count_next    = '0;
              end
              CMD_ADD: begin
                result.rsp.ok = add_ok;
                if (add_ok) begin
                  count_next = CNT_W'(count + 1'b1);
                end
              end
              CMD_REMOVE: begin
                result.rsp.ok = found_next;
                if (found_next) begin
                  count_next = CNT_W'(count - 1'b1);
                end
              end
              CMD_RENAME: begin
                result.rsp.ok = found_next;
              end
              CMD_LOOKUP: begin
                result.rsp.ok      = found_next;
                result.rsp.tag_out = tag_res_next;
              end
              default: begin
                result.rsp.ok = 1'b0;
              end
            endcase
            result.rsp.count = COUNT_W'(count_next);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
